// File: sv/gha_pkg.sv
// Shared types, widths, register codes and reset values for the heatmap argmax detector.
package gha_pkg;

  localparam int MAX_GRID_DEF    = 64;
  localparam int MAX_CLASSES_DEF = 32;

  localparam int RAW_W    = 8;
  localparam int ZP_W     = 8;
  localparam int SCALE_W  = 24;
  localparam int SCORE_W  = 33;
  localparam int GRID_W   = 7;
  localparam int CLS_CNT_W = 6;
  localparam int CELL_W   = 12;

  localparam int COL_OUT_W    = 6;
  localparam int ROW_OUT_W    = 6;
  localparam int CENTER_W     = 18;
  localparam int CLASS_OUT_W  = 5;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_FIELDS_W = COL_OUT_W + ROW_OUT_W + 2 * CENTER_W + CLASS_OUT_W + SCORE_W;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS   = 3'd0,
    REG_GRID_ROWS   = 3'd1,
    REG_CLASS_COUNT = 3'd2,
    REG_CELL_WIDTH  = 3'd3,
    REG_CELL_HEIGHT = 3'd4,
    REG_ZERO_POINT  = 3'd5,
    REG_SCORE_SCALE = 3'd6,
    REG_THRESHOLD   = 3'd7
  } cfg_reg_t;

  localparam logic [GRID_W-1:0]         GRID_COLS_RST   = 7'd12;
  localparam logic [GRID_W-1:0]         GRID_ROWS_RST   = 7'd12;
  localparam logic [CLS_CNT_W-1:0]      CLASS_COUNT_RST = 6'd2;
  localparam logic [CELL_W-1:0]         CELL_WIDTH_RST  = 12'd8;
  localparam logic [CELL_W-1:0]         CELL_HEIGHT_RST = 12'd8;
  localparam logic signed [ZP_W-1:0]    ZERO_POINT_RST  = 8'sd0;
  localparam logic [SCALE_W-1:0]        SCORE_SCALE_RST = 24'd65536;
  localparam logic signed [SCORE_W-1:0] THRESHOLD_RST   = 33'sd32768000;

  // Dequantizer settings handed as one group.
  typedef struct packed {
    logic signed [ZP_W-1:0] zp_offset;
    logic [SCALE_W-1:0]     score_scale;
  } quant_cfg_t;

endpackage

// File: sv/gha_dequant.sv
// Fixed-point dequantizer: (raw - zp_offset) * score_scale in 2^-16 units.
module gha_dequant (
  input  logic signed [gha_pkg::RAW_W-1:0]   raw_score,
  input  gha_pkg::quant_cfg_t                qcfg,
  output logic signed [gha_pkg::SCORE_W-1:0] score
);
  import gha_pkg::*;

  logic signed [RAW_W:0]       diff;
  logic signed [SCALE_W:0]     scale_s;
  logic signed [SCORE_W:0]     prod;

  always_comb begin
    diff    = (RAW_W + 1)'(raw_score) - (RAW_W + 1)'(qcfg.zp_offset);
    scale_s = $signed({1'b0, qcfg.score_scale});
    prod    = (SCORE_W + 1)'(diff) * (SCORE_W + 1)'(scale_s);
    // |diff| <= 255 and scale < 2^24, so the product fits in 33 bits signed
    score   = prod[SCORE_W-1:0];
  end

endmodule

// File: sv/grid_heatmap_argmax_detector_core.sv
// Top level of the grid heatmap argmax detector.
// Usage: int8 class scores enter on in_* one item per cycle, row-major cells with
// the classes of a cell innermost. Each score is dequantized and compared with the
// running best of its cell; at a cell's last class one detection item leaves on
// out_* if some class strictly beat the threshold, otherwise nothing leaves.
// Registers are written on cfg_* (index, data); cfg_ready is always high. Write
// them only while no item is in flight.
// Path: a score taken on in_* goes to the input register; its detection, if any, goes
// from there into the result register and is presented on out_*.
// Throughput: one score per cycle while in_tready is high, set by the combinational
// dequantize multiply and 33-bit compare that update the running best.
// Reset (rst_n low, synchronous) loads the default registers, clears the class,
// column and row counters and empties both register stages.
// When the receiver stalls, the pending detection holds in the result register;
// scores that do not finish a cell keep flowing, and in_tready drops only when
// a cell-ending score would need the occupied result register.
module grid_heatmap_argmax_detector_core #(
  parameter int MAX_GRID    = gha_pkg::MAX_GRID_DEF,
  parameter int MAX_CLASSES = gha_pkg::MAX_CLASSES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // tdata: raw_score[7:0]
  input  logic [gha_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: cell_col[5:0], cell_row[11:6], center_x[29:12], center_y[47:30],
  //        best_class[52:48], best_score[85:53], zero[87:86]
  output logic [gha_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gha_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gha_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gha_pkg::*;

  localparam int GIW  = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int CIW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int MXW  = (GIW > CIW) ? ((GIW > GRID_W) ? GIW : GRID_W)
                                    : ((CIW > GRID_W) ? CIW : GRID_W);
  localparam int NW   = MXW + 2;
  localparam int CXW  = (GIW + CELL_W + 1 > CENTER_W) ? GIW + CELL_W + 1 : CENTER_W;
  localparam int GXW  = (GIW > COL_OUT_W) ? GIW : COL_OUT_W;
  localparam int KXW  = (CIW > CLASS_OUT_W) ? CIW : CLASS_OUT_W;
  localparam logic [NW-1:0] MAX_GRID_N    = NW'(MAX_GRID);
  localparam logic [NW-1:0] MAX_CLASSES_N = NW'(MAX_CLASSES);

  // configuration registers
  logic [GRID_W-1:0]         grid_cols_r, grid_rows_r;
  logic [CLS_CNT_W-1:0]      class_count_r;
  logic [CELL_W-1:0]         cell_width_r, cell_height_r;
  logic signed [ZP_W-1:0]    zp_offset_r;
  logic [SCALE_W-1:0]        score_scale_r;
  logic signed [SCORE_W-1:0] threshold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r   <= GRID_COLS_RST;
      grid_rows_r   <= GRID_ROWS_RST;
      class_count_r <= CLASS_COUNT_RST;
      cell_width_r  <= CELL_WIDTH_RST;
      cell_height_r <= CELL_HEIGHT_RST;
      zp_offset_r   <= ZERO_POINT_RST;
      score_scale_r <= SCORE_SCALE_RST;
      threshold_r   <= THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_COLS:   grid_cols_r   <= cfg_data[GRID_W-1:0];
        REG_GRID_ROWS:   grid_rows_r   <= cfg_data[GRID_W-1:0];
        REG_CLASS_COUNT: class_count_r <= cfg_data[CLS_CNT_W-1:0];
        REG_CELL_WIDTH:  cell_width_r  <= cfg_data[CELL_W-1:0];
        REG_CELL_HEIGHT: cell_height_r <= cfg_data[CELL_W-1:0];
        REG_ZERO_POINT:  zp_offset_r   <= cfg_data[ZP_W-1:0];
        REG_SCORE_SCALE: score_scale_r <= cfg_data[SCALE_W-1:0];
        REG_THRESHOLD:   threshold_r   <= cfg_data[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                    in_valid_r;
  logic signed [RAW_W-1:0] raw_r;
  logic                    proc_fire;

  assign in_tready = !in_valid_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      raw_r <= in_tdata[RAW_W-1:0];
    end
  end

  // dequantize
  quant_cfg_t                qcfg;
  logic signed [SCORE_W-1:0] score;

  assign qcfg.zp_offset   = zp_offset_r;
  assign qcfg.score_scale = score_scale_r;

  gha_dequant u_dequant (
    .raw_score (raw_r),
    .qcfg      (qcfg),
    .score     (score)
  );

  // cell tracking state
  logic [CIW-1:0]            class_idx_r, class_idx_nxt;
  logic [GIW-1:0]            col_idx_r, col_idx_nxt;
  logic [GIW-1:0]            row_idx_r, row_idx_nxt;
  logic signed [SCORE_W-1:0] best_score_r, best_score_nxt;
  logic [CIW-1:0]            best_class_r, best_class_nxt;
  logic                      found_r, found_nxt;

  logic [NW-1:0] ncls, ncol, nrow;
  logic          last_class, last_col, last_row;
  logic          emit, out_free;
  logic signed [SCORE_W-1:0] base_score;
  logic [CIW-1:0]            base_class;
  logic                      base_found;

  // effective counts: clamp to [1, MAX]
  always_comb begin
    if (class_count_r == '0) ncls = NW'(1);
    else if (NW'(class_count_r) > MAX_CLASSES_N) ncls = MAX_CLASSES_N;
    else ncls = NW'(class_count_r);
    if (grid_cols_r == '0) ncol = NW'(1);
    else if (NW'(grid_cols_r) > MAX_GRID_N) ncol = MAX_GRID_N;
    else ncol = NW'(grid_cols_r);
    if (grid_rows_r == '0) nrow = NW'(1);
    else if (NW'(grid_rows_r) > MAX_GRID_N) nrow = MAX_GRID_N;
    else nrow = NW'(grid_rows_r);
  end

  always_comb begin
    last_class = (NW'(class_idx_r) + NW'(1)) >= ncls;
    last_col   = (NW'(col_idx_r) + NW'(1)) >= ncol;
    last_row   = (NW'(row_idx_r) + NW'(1)) >= nrow;

    // reload the running best from the threshold at a cell's first class
    if (class_idx_r == '0) begin
      base_score = threshold_r;
      base_class = '0;
      base_found = 1'b0;
    end else begin
      base_score = best_score_r;
      base_class = best_class_r;
      base_found = found_r;
    end

    if (score > base_score) begin
      best_score_nxt = score;
      best_class_nxt = class_idx_r;
      found_nxt      = 1'b1;
    end else begin
      best_score_nxt = base_score;
      best_class_nxt = base_class;
      found_nxt      = base_found;
    end

    emit = last_class && found_nxt;

    if (last_class) begin
      class_idx_nxt = '0;
      if (last_col) begin
        col_idx_nxt = '0;
        row_idx_nxt = last_row ? '0 : row_idx_r + GIW'(1);
      end else begin
        col_idx_nxt = col_idx_r + GIW'(1);
        row_idx_nxt = row_idx_r;
      end
    end else begin
      class_idx_nxt = class_idx_r + CIW'(1);
      col_idx_nxt   = col_idx_r;
      row_idx_nxt   = row_idx_r;
    end
  end

  logic out_valid_r;

  assign out_free  = !out_valid_r || out_tready;
  // hold a cell-ending item that emits a detection only while the result register is occupied and not being read
  assign proc_fire = in_valid_r && (!emit || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_idx_r  <= '0;
      col_idx_r    <= '0;
      row_idx_r    <= '0;
      best_score_r <= '0;
      best_class_r <= '0;
      found_r      <= 1'b0;
    end else if (proc_fire) begin
      class_idx_r  <= class_idx_nxt;
      col_idx_r    <= col_idx_nxt;
      row_idx_r    <= row_idx_nxt;
      best_score_r <= best_score_nxt;
      best_class_r <= best_class_nxt;
      found_r      <= found_nxt;
    end
  end

  // box centers
  logic [CXW-1:0] cx_full, cy_full;
  logic [GXW-1:0] col_ext, row_ext;
  logic [KXW-1:0] class_ext;

  always_comb begin
    cx_full   = CXW'(col_idx_r) * CXW'(cell_width_r) + CXW'(cell_width_r >> 1);
    cy_full   = CXW'(row_idx_r) * CXW'(cell_height_r) + CXW'(cell_height_r >> 1);
    col_ext   = GXW'(col_idx_r);
    row_ext   = GXW'(row_idx_r);
    class_ext = KXW'(best_class_nxt);
  end

  // result register
  logic [OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      out_data_r <= OUT_DATA_W'({best_score_nxt,
                                 class_ext[CLASS_OUT_W-1:0],
                                 cy_full[CENTER_W-1:0],
                                 cx_full[CENTER_W-1:0],
                                 row_ext[ROW_OUT_W-1:0],
                                 col_ext[COL_OUT_W-1:0]});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: tb/gha_detection_checker.sv
// Checker for the heatmap argmax detector: tracks the running best per cell and compares detections.
module gha_detection_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [gha_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [gha_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [gha_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gha_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                mismatches,
  output int                                outstanding
);
  import gha_pkg::*;

  localparam int ROW_LSB   = COL_OUT_W;
  localparam int CX_LSB    = ROW_LSB + ROW_OUT_W;
  localparam int CY_LSB    = CX_LSB + CENTER_W;
  localparam int CLS_LSB   = CY_LSB + CENTER_W;
  localparam int SCORE_LSB = CLS_LSB + CLASS_OUT_W;

  typedef struct {
    logic [COL_OUT_W-1:0]      col;
    logic [ROW_OUT_W-1:0]      row;
    logic [CENTER_W-1:0]       cx;
    logic [CENTER_W-1:0]       cy;
    logic [CLASS_OUT_W-1:0]    cls;
    logic signed [SCORE_W-1:0] score;
  } detection_t;

  detection_t detections_due[$];

  // Local copy of the register file.
  logic [GRID_W-1:0]         cols_reg;
  logic [GRID_W-1:0]         rows_reg;
  logic [CLS_CNT_W-1:0]      classes_reg;
  logic [CELL_W-1:0]         cell_w_reg;
  logic [CELL_W-1:0]         cell_h_reg;
  logic signed [ZP_W-1:0]    zp_reg;
  logic [SCALE_W-1:0]        scale_reg;
  logic signed [SCORE_W-1:0] thr_reg;

  // Scan position and running best of the current cell.
  int     cls_idx;
  int     col_idx;
  int     row_idx;
  longint best_val;
  int     best_idx;
  bit     beat_thr;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] got,
                             input logic signed [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic int clamp_count(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic fold_score(input logic [RAW_W-1:0] raw);
    int         ncls;
    int         ncol;
    int         nrow;
    longint     val;
    longint     cx;
    longint     cy;
    detection_t det;
    ncls = clamp_count(int'(classes_reg), MAX_CLASSES_DEF);
    ncol = clamp_count(int'(cols_reg), MAX_GRID_DEF);
    nrow = clamp_count(int'(rows_reg), MAX_GRID_DEF);
    val = (longint'($signed(raw)) - longint'(zp_reg)) * longint'(scale_reg);

    // Each cell starts from the threshold; a tie never replaces the best.
    if (cls_idx == 0) begin
      best_val = longint'(thr_reg);
      best_idx = 0;
      beat_thr = 1'b0;
    end
    if (val > best_val) begin
      best_val = val;
      best_idx = cls_idx;
      beat_thr = 1'b1;
    end

    if (cls_idx + 1 >= ncls) begin
      if (beat_thr) begin
        cx = longint'(col_idx) * longint'(cell_w_reg) + longint'(cell_w_reg >> 1);
        cy = longint'(row_idx) * longint'(cell_h_reg) + longint'(cell_h_reg >> 1);
        det.col   = col_idx[COL_OUT_W-1:0];
        det.row   = row_idx[ROW_OUT_W-1:0];
        det.cx    = cx[CENTER_W-1:0];
        det.cy    = cy[CENTER_W-1:0];
        det.cls   = best_idx[CLASS_OUT_W-1:0];
        det.score = best_val[SCORE_W-1:0];
        detections_due.insert(detections_due.size(), det);
      end
      cls_idx = 0;
      // Counters past a shrunken limit wrap at the next cell end.
      if (col_idx + 1 >= ncol) begin
        col_idx = 0;
        row_idx = (row_idx + 1 >= nrow) ? 0 : row_idx + 1;
      end else begin
        col_idx++;
      end
    end else begin
      cls_idx++;
    end
  endtask

  task automatic check_detection(input logic [OUT_DATA_W-1:0] d);
    detection_t want;
    if (detections_due.size() == 0) begin
      report_mismatch($sformatf("detection for cell %0d,%0d with none expected",
                                d[0 +: COL_OUT_W], d[ROW_LSB +: ROW_OUT_W]));
    end else begin
      want = detections_due.pop_front();
      check_field("cell_col", d[0 +: COL_OUT_W], want.col);
      check_field("cell_row", d[ROW_LSB +: ROW_OUT_W], want.row);
      check_field("center_x", d[CX_LSB +: CENTER_W], want.cx);
      check_field("center_y", d[CY_LSB +: CENTER_W], want.cy);
      check_field("best_class", d[CLS_LSB +: CLASS_OUT_W], want.cls);
      check_field("best_score", $signed(d[SCORE_LSB +: SCORE_W]), want.score);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_t'(idx))
      REG_GRID_COLS:   cols_reg    = data[GRID_W-1:0];
      REG_GRID_ROWS:   rows_reg    = data[GRID_W-1:0];
      REG_CLASS_COUNT: classes_reg = data[CLS_CNT_W-1:0];
      REG_CELL_WIDTH:  cell_w_reg  = data[CELL_W-1:0];
      REG_CELL_HEIGHT: cell_h_reg  = data[CELL_W-1:0];
      REG_ZERO_POINT:  zp_reg      = data[ZP_W-1:0];
      REG_SCORE_SCALE: scale_reg   = data[SCALE_W-1:0];
      REG_THRESHOLD:   thr_reg     = data[SCORE_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cols_reg    = GRID_COLS_RST;
      rows_reg    = GRID_ROWS_RST;
      classes_reg = CLASS_COUNT_RST;
      cell_w_reg  = CELL_WIDTH_RST;
      cell_h_reg  = CELL_HEIGHT_RST;
      zp_reg      = ZERO_POINT_RST;
      scale_reg   = SCORE_SCALE_RST;
      thr_reg     = THRESHOLD_RST;
      cls_idx     = 0;
      col_idx     = 0;
      row_idx     = 0;
      best_val    = 0;
      best_idx    = 0;
      beat_thr    = 1'b0;
      detections_due.delete();
      outstanding <= 0;
    end else begin
      // Compare first so a detection never matches an item taken at the same edge.
      if (out_tvalid && out_tready) check_detection(out_tdata);
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_tvalid && in_tready) fold_score(in_tdata);
      outstanding <= detections_due.size();
    end
  end

endmodule

// File: tb/tb.sv
// Testbench top for the heatmap argmax detector: score stimulus, register settings and verdict.
module tb;
  import gha_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int QUIET_FROM   = 950;

  typedef struct {
    longint cols;
    longint rows;
    longint classes;
    longint cell_w;
    longint cell_h;
    longint zp;
    longint scale;
    longint thr;
  } setting_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int mismatches;
  int outstanding;
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  int rx_hold      = 0;
  int idle_cycles  = 0;
  int sent         = 0;

  grid_heatmap_argmax_detector_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  gha_detection_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: stall in bursts of random length while rx_stall_pct is nonzero.
  always @(posedge clk) begin
    if (!rst_n || rx_stall_pct == 0) begin
      out_tready <= 1'b1;
      rx_hold    <= 0;
    end else if (rx_hold != 0) begin
      out_tready <= 1'b0;
      rx_hold    <= rx_hold - 1;
    end else if ($urandom_range(99) < rx_stall_pct) begin
      out_tready <= 1'b0;
      rx_hold    <= $urandom_range(18, 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input longint value, input int width);
    logic [CFG_DATA_W-1:0] noise;
    logic [CFG_DATA_W-1:0] keep;
    noise[31:0] = $urandom;
    noise[32]   = $urandom_range(1);
    keep = '1;
    keep = keep >> (CFG_DATA_W - width);
    // Unused upper bits carry noise; the register takes only its own width.
    cfg_index <= idx;
    cfg_data  <= (noise & ~keep) | (value[CFG_DATA_W-1:0] & keep);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input setting_t s);
    write_reg(REG_GRID_COLS, s.cols, GRID_W);
    write_reg(REG_GRID_ROWS, s.rows, GRID_W);
    write_reg(REG_CLASS_COUNT, s.classes, CLS_CNT_W);
    write_reg(REG_CELL_WIDTH, s.cell_w, CELL_W);
    write_reg(REG_CELL_HEIGHT, s.cell_h, CELL_W);
    write_reg(REG_ZERO_POINT, s.zp, ZP_W);
    write_reg(REG_SCORE_SCALE, s.scale, SCALE_W);
    write_reg(REG_THRESHOLD, s.thr, SCORE_W);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_detections();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Drain, then let a score that ends no cell clear the pipeline.
  task automatic settle();
    wait_for_detections();
    repeat (4) @(posedge clk);
  endtask

  task automatic send_score(input int raw);
    if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    in_tdata  <= raw[IN_DATA_W-1:0];
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  function automatic longint pick_grid();
    case ($urandom_range(11))
      0: return 0;
      1: return 1;
      2: return 64;
      3: return 127;
      default: return $urandom_range(6, 2);
    endcase
  endfunction

  function automatic longint pick_classes();
    case ($urandom_range(11))
      0: return 0;
      1: return 1;
      2: return 32;
      3: return 63;
      default: return $urandom_range(6, 2);
    endcase
  endfunction

  function automatic longint pick_cell();
    case ($urandom_range(7))
      0: return 0;
      1: return 1;
      2: return 4095;
      default: return $urandom_range(4095);
    endcase
  endfunction

  // Place the threshold near a real score so that cells both pass and fail.
  function automatic longint pick_threshold(input longint zp, input longint scale);
    longint pivot;
    case ($urandom_range(9))
      0: return -64'sd4278190080;
      1: return 64'sd4278190080;
      2: return -1;
      default: begin
        pivot = longint'($urandom_range(255)) - 128;
        return (pivot - zp) * scale + longint'($urandom_range(2)) - 1;
      end
    endcase
  endfunction

  function automatic setting_t random_setting();
    setting_t s;
    s.cols    = pick_grid();
    s.rows    = pick_grid();
    s.classes = pick_classes();
    s.cell_w  = pick_cell();
    s.cell_h  = pick_cell();
    case ($urandom_range(5))
      0: s.zp = -128;
      1: s.zp = 127;
      2: s.zp = 0;
      default: s.zp = longint'($urandom_range(255)) - 128;
    endcase
    case ($urandom_range(7))
      0: s.scale = 0;
      1: s.scale = 16777215;
      2: s.scale = 65536;
      3: s.scale = $urandom_range(300, 1);
      default: s.scale = $urandom_range(16777215);
    endcase
    s.thr = pick_threshold(s.zp, s.scale);
    return s;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 40;
    endcase
  endfunction

  initial begin
    int n;
    int cluster;
    bit quiet;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Max scale, zero threshold: all-zero cell stays silent, ties keep the earlier class.
    apply_setting('{3, 2, 3, 4095, 4095, -128, 16777215, 0});
    send_score(-128); send_score(-128); send_score(-128);
    send_score(127);  send_score(127);  send_score(-128);
    send_score(-128); send_score(5);    send_score(5);
    settle();
    // Zero class count and oversized columns, single row, minimum threshold.
    apply_setting('{127, 0, 0, 1, 1, 127, 1, -64'sd4278190080});
    send_score(-128); send_score(127); send_score(0); send_score(-1);
    settle();
    // Zero scale against a threshold of -1, zero cell width.
    apply_setting('{2, 2, 2, 0, 4095, -128, 0, -1});
    send_score(5); send_score(-7); send_score(127); send_score(-128);
    settle();
    // Score equal to the threshold does not pass.
    apply_setting('{2, 2, 2, 100, 100, 0, 65536, 655360});
    send_score(10); send_score(10); send_score(10); send_score(11);
    settle();
    // Maximum threshold is out of reach.
    apply_setting('{2, 2, 2, 7, 9, -128, 16777215, 64'sd4278190080});
    send_score(127); send_score(127);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      apply_setting(random_setting());
      quiet = (sent >= QUIET_FROM);
      tx_gap_pct = quiet ? 0 : pick_pct();
      rx_stall_pct <= quiet ? 0 : pick_pct();
      n = $urandom_range(140, 30);
      cluster = $urandom_range(255);
      repeat (n) begin
        if (!quiet && $urandom_range(99) == 0) wait_for_detections();
        // Clustered scores make ties and near-threshold values common.
        if ($urandom_range(1) != 0) send_score(cluster + $urandom_range(3));
        else send_score($urandom_range(255));
      end
    end

    wait_for_detections();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: grid_heatmap_argmax_detector_core.f
sv/gha_pkg.sv
sv/gha_dequant.sv
sv/grid_heatmap_argmax_detector_core.sv
tb/gha_detection_checker.sv
tb/tb.sv
